### hdl/acs_pkg.sv
// acs_pkg: shared types, constants and aes helper functions
// used by the front, the aes round unit and the top level
package acs_pkg;

  typedef enum logic [1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1,
    RegIvPre   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nb;
    logic        last;
    logic        need_blk;
    logic [31:0] ctr;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic [127:0] rk,
                                            input logic mix);
    logic [127:0] t;
    logic [7:0] q0, q1, q2, q3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127-8*(i+4*c) -: 8] = sbox(byte_of(s, i + 4*((c+i) & 3)));
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        q0 = t[127-32*c -: 8]; q1 = t[119-32*c -: 8];
        q2 = t[111-32*c -: 8]; q3 = t[103-32*c -: 8];
        al = q0 ^ q1 ^ q2 ^ q3;
        t[127-32*c -: 8] = q0 ^ al ^ xtime(q0 ^ q1);
        t[119-32*c -: 8] = q1 ^ al ^ xtime(q1 ^ q2);
        t[111-32*c -: 8] = q2 ^ al ^ xtime(q2 ^ q3);
        t[103-32*c -: 8] = q3 ^ al ^ xtime(q3 ^ q0);
      end
    end
    return t ^ rk;
  endfunction

endpackage

### hdl/aes_ctr_stream_cipher.sv
// aes_ctr_stream_cipher: aes-128 counter mode, eight bytes per transaction
// depends on acs_pkg, acs_front, acs_back
//
// input channel: in_valid_i/in_stall_o with data, valid count, first, last
// and start counter. output channel: out_valid_o/out_stall_i with the
// enciphered bytes, valid count and last flag; bytes past the count are zero.
// the front tracks counter and half and queues up to QueueDepth jobs (four by default).
// a job on a first half starts the round unit, one round per cycle: the block
// is loaded, ten rounds run and the result goes to the output register when
// that is free; a job on a second half uses the held keystream block.
// the round unit holds one block at a time: the next block is loaded only
// when its first-half job heads the queue and the previous block is done.
// the apb port writes key and iv prefix at byte addresses 0, 8 and 16 with
// 64-bit data; write them only while idle.
// reset clears the queue, the counter (zero) and the half (first half).
// when the receiver stalls, the output register holds and the queue fills,
// then in_stall_o rises.
module aes_ctr_stream_cipher #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_in_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [31:0] start_counter_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] data_out_o,
  output logic [3:0]  valid_bytes_out_o,
  output logic        last_out_o
);
  logic [63:0] key_hi_q, key_lo_q, iv_q;
  logic        wr, job_valid, job_pop;
  logic [1:0]  ridx;
  acs_pkg::job_t job;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:3];

  always_comb begin
    case (ridx)
      acs_pkg::RegKeyHigh: prdata = key_hi_q;
      acs_pkg::RegKeyLow:  prdata = key_lo_q;
      acs_pkg::RegIvPre:   prdata = iv_q;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0; key_lo_q <= '0; iv_q <= '0;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (ridx)
        acs_pkg::RegKeyHigh: key_hi_q <= pwdata;
        acs_pkg::RegKeyLow:  key_lo_q <= pwdata;
        acs_pkg::RegIvPre:   iv_q <= pwdata;
        default: ;
      endcase
    end
  end

  acs_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_in_i, .valid_bytes_i,
    .first_i, .last_i, .start_counter_i,
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  acs_back u_back (
    .clk_i, .rst_ni, .key_i({key_hi_q, key_lo_q}), .iv_i(iv_q),
    .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .out_valid_o, .out_stall_i, .data_out_o, .valid_bytes_out_o, .last_out_o
  );

  ap_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid) else $error("pop from empty queue");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_out_o))
    else $error("stalled output changed");
  ap_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> valid_bytes_out_o != 4'd0 && valid_bytes_out_o <= 4'd8)
    else $error("bad valid count");
endmodule

### hdl/acs_front.sv
// acs_front: accepts transactions, tracks counter and half, queues jobs
// depends on acs_pkg
module acs_front #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [63:0]   data_in_i,
  input  logic [3:0]    valid_bytes_i,
  input  logic          first_i,
  input  logic          last_i,
  input  logic [31:0]   start_counter_i,
  output logic          job_valid_o,
  input  logic          job_pop_i,
  output acs_pkg::job_t job_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  acs_pkg::job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic [31:0]   ctr_q, ctr_d, ctr_use;
  logic          half_q, half_d, half_use, push;
  logic [3:0]    nb;
  acs_pkg::job_t job_w;

  assign in_stall_o  = (cnt_q == (AW+1)'(Depth));
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rp_q];

  always_comb begin
    nb       = (valid_bytes_i == 4'd0 || valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
    ctr_use  = first_i ? start_counter_i : ctr_q;
    half_use = first_i ? 1'b0 : half_q;
    ctr_d    = ctr_use;
    half_d   = !half_use;
    if (half_use || last_i) begin
      ctr_d  = ctr_use + 32'd1;
      half_d = 1'b0;
    end
    job_w = '{data: data_in_i, nb: nb, last: last_i, need_blk: !half_use, ctr: ctr_use};
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; ctr_q <= '0; half_q <= 1'b0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
        ctr_q <= ctr_d; half_q <= half_d;
      end
      if (job_pop_i) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(job_pop_i);
    end
  end
endmodule

### hdl/acs_back.sv
// acs_back: round-per-cycle aes core, keystream hold and output register
// depends on acs_pkg
module acs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [127:0]  key_i,
  input  logic [63:0]   iv_i,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  acs_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [63:0]   data_out_o,
  output logic [3:0]    valid_bytes_out_o,
  output logic          last_out_o
);
  logic [127:0] st_q, rk_q, ks_q;
  logic [7:0]   rc_q;
  logic [3:0]   rnd_q;
  logic         busy_q, ov_q, ks_ok_q;
  logic [127:0] rk_n;
  logic         out_free, can_fin;
  logic [63:0]  half, mask;

  assign out_free  = !ov_q || !out_stall_i;
  assign rk_n      = acs_pkg::next_key(rk_q, rc_q);
  // a second-half job needs the held block; a first-half job needs its block done
  assign can_fin   = job_valid_i && out_free &&
                     (job_i.need_blk ? (busy_q && rnd_q == 4'd11) : ks_ok_q);
  assign job_pop_o = can_fin;
  assign out_valid_o = ov_q;

  always_comb begin
    half = job_i.need_blk ? st_q[127:64] : ks_q[63:0];
    mask = ~(64'hffff_ffff_ffff_ffff >> (8 * job_i.nb));
    if (job_i.nb == 4'd8) mask = '1;
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_i.need_blk && !busy_q) begin
      st_q <= {iv_i, 32'd0, job_i.ctr} ^ key_i;
      rk_q <= key_i;
      rc_q <= 8'h01;
    end else if (busy_q && rnd_q <= 4'd10) begin
      st_q <= acs_pkg::round_fn(st_q, rk_n, rnd_q != 4'd10);
      rk_q <= rk_n;
      rc_q <= acs_pkg::xtime(rc_q);
    end
    if (can_fin && job_i.need_blk) ks_q <= st_q;
    if (can_fin) begin
      data_out_o        <= (job_i.data ^ half) & mask;
      valid_bytes_out_o <= job_i.nb;
      last_out_o        <= job_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; rnd_q <= '0; ov_q <= 1'b0; ks_ok_q <= 1'b0;
    end else begin
      if (job_valid_i && job_i.need_blk && !busy_q) begin
        busy_q <= 1'b1; rnd_q <= 4'd1;
      end else if (busy_q && rnd_q <= 4'd10) begin
        rnd_q <= rnd_q + 4'd1;
      end
      if (can_fin && job_i.need_blk) begin
        busy_q <= 1'b0; ks_ok_q <= 1'b1;
      end
      if (can_fin) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end
endmodule
